[rtl/qsn_pkg.sv]
`timescale 1ns / 1ps

package qsn_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W = 33;
  localparam int RES_W = 44;
  localparam int AXIS_FRAC = 30;
  localparam int SCALE_FRAC = 24;
  localparam int NORM_W = 30;
  localparam int NORM_MSB = 29;
  localparam int ROOT_STEPS = 31;

  localparam logic [31:0] ONE_SCALE = 32'd1 << SCALE_FRAC;

  localparam logic [1:0] KIND_PLANE = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_CYL = 2'd2;
  localparam logic [1:0] KIND_CONE = 2'd3;

  // Item data that rides alongside the axis normalizer.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0][DIFF_W-1:0] v;
    logic [31:0] scale;
  } side_t;

endpackage

[rtl/qsn_norm.sv]
`timescale 1ns / 1ps

module qsn_norm #(
  parameter int IN_W = 32,
  parameter int FRAC = 30,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [IN_W-1:0]   in_v [3],
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic signed [31:0]       out_n [3],
  output logic                     out_zero,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int PW = $clog2(IN_W);
  localparam int RS = qsn_pkg::ROOT_STEPS;
  localparam int NW = qsn_pkg::NORM_W;

  // Stage 1: magnitudes.
  logic              s1_valid_r;
  logic [IN_W-1:0]   s1_mag_r [3];
  logic [2:0]        s1_neg_r;
  logic [SIDE_W-1:0] s1_side_r;
  // Stage 2: leading one of the largest magnitude.
  logic              s2_valid_r;
  logic [IN_W-1:0]   s2_mag_r [3];
  logic [2:0]        s2_neg_r;
  logic [PW-1:0]     s2_pos_r;
  logic              s2_zero_r;
  logic [SIDE_W-1:0] s2_side_r;
  // Stage 3: scaled to 30 bits.
  logic              s3_valid_r;
  logic [NW-1:0]     s3_m_r [3];
  logic [2:0]        s3_neg_r;
  logic              s3_zero_r;
  logic [SIDE_W-1:0] s3_side_r;
  // Stage 4: squares.
  logic              s4_valid_r;
  logic [2*NW-1:0]   s4_sq_r [3];
  logic [NW-1:0]     s4_m_r [3];
  logic [2:0]        s4_neg_r;
  logic              s4_zero_r;
  logic [SIDE_W-1:0] s4_side_r;

  // Square root pipeline, one result bit per stage.
  logic [63:0]       sv_r [0:RS];
  logic [63:0]       sr_r [0:RS];
  logic [NW-1:0]     sm_r [0:RS][3];
  logic [2:0]        sneg_r [0:RS];
  logic              szero_r [0:RS];
  logic              svalid_r [0:RS];
  logic [SIDE_W-1:0] sside_r [0:RS];

  // Division pipeline, one quotient bit per stage for each component.
  logic [30:0]       dr_r [0:FRAC][3];
  logic [FRAC:0]     dq_r [0:FRAC][3];
  logic [30:0]       dlen_r [0:FRAC];
  logic [2:0]        dneg_r [0:FRAC];
  logic              dzero_r [0:FRAC];
  logic              dvalid_r [0:FRAC];
  logic [SIDE_W-1:0] dside_r [0:FRAC];

  logic              o_valid_r;
  logic signed [31:0] o_n_r [3];
  logic              o_zero_r;
  logic [SIDE_W-1:0] o_side_r;

  logic [IN_W-1:0]   mag_nxt [3];
  logic [IN_W-1:0]   or_nxt;
  logic [PW-1:0]     pos_nxt;
  logic [NW-1:0]     m_nxt [3];
  logic [30:0]       len_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = in_v[i][IN_W-1] ? IN_W'(-in_v[i]) : IN_W'(in_v[i]);
    end
  end

  always_comb begin
    or_nxt = s1_mag_r[0] | s1_mag_r[1] | s1_mag_r[2];
    pos_nxt = '0;
    for (int k = 0; k < IN_W; k++) begin
      if (or_nxt[k]) begin
        pos_nxt = PW'(k);
      end
    end
  end

  // A right shift drops low bits, the same as halving repeatedly.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s2_pos_r >= PW'(qsn_pkg::NORM_MSB)) begin
        m_nxt[i] = NW'(s2_mag_r[i] >> (s2_pos_r - PW'(qsn_pkg::NORM_MSB)));
      end else begin
        m_nxt[i] = NW'(s2_mag_r[i] << (PW'(qsn_pkg::NORM_MSB) - s2_pos_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      svalid_r[0] <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      svalid_r[0] <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag_r[i] <= mag_nxt[i];
        s1_neg_r[i] <= in_v[i][IN_W-1];
        s2_mag_r[i] <= s1_mag_r[i];
        s3_m_r[i] <= m_nxt[i];
        s4_sq_r[i] <= (2*NW)'(s3_m_r[i]) * (2*NW)'(s3_m_r[i]);
        s4_m_r[i] <= s3_m_r[i];
        sm_r[0][i] <= s4_m_r[i];
      end
      s1_side_r <= in_side;
      s2_neg_r <= s1_neg_r;
      s2_pos_r <= pos_nxt;
      s2_zero_r <= (or_nxt == '0);
      s2_side_r <= s1_side_r;
      s3_neg_r <= s2_neg_r;
      s3_zero_r <= s2_zero_r;
      s3_side_r <= s2_side_r;
      s4_neg_r <= s3_neg_r;
      s4_zero_r <= s3_zero_r;
      s4_side_r <= s3_side_r;
      sv_r[0] <= 64'(s4_sq_r[0]) + 64'(s4_sq_r[1]) + 64'(s4_sq_r[2]);
      sr_r[0] <= '0;
      sneg_r[0] <= s4_neg_r;
      szero_r[0] <= s4_zero_r;
      sside_r[0] <= s4_side_r;
    end
  end

  for (genvar j = 0; j < RS; j++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (2 * (RS - 1 - j));
    logic [63:0] t_sum;
    logic [63:0] v_nxt;
    logic [63:0] r_nxt;

    always_comb begin
      t_sum = sr_r[j] + BIT;
      if (sv_r[j] >= t_sum) begin
        v_nxt = sv_r[j] - t_sum;
        r_nxt = (sr_r[j] >> 1) + BIT;
      end else begin
        v_nxt = sv_r[j];
        r_nxt = sr_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svalid_r[j+1] <= 1'b0;
      end else if (en) begin
        svalid_r[j+1] <= svalid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sv_r[j+1] <= v_nxt;
        sr_r[j+1] <= r_nxt;
        sm_r[j+1] <= sm_r[j];
        sneg_r[j+1] <= sneg_r[j];
        szero_r[j+1] <= szero_r[j];
        sside_r[j+1] <= sside_r[j];
      end
    end
  end

  assign len_w = sr_r[RS][30:0];

  // The length is never below the largest magnitude, so the top quotient
  // bit has weight one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r[0] <= 1'b0;
    end else if (en) begin
      dvalid_r[0] <= svalid_r[RS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, sm_r[RS][i]} >= len_w) begin
          dr_r[0][i] <= {1'b0, sm_r[RS][i]} - len_w;
          dq_r[0][i] <= (FRAC+1)'(1);
        end else begin
          dr_r[0][i] <= {1'b0, sm_r[RS][i]};
          dq_r[0][i] <= '0;
        end
      end
      dlen_r[0] <= len_w;
      dneg_r[0] <= sneg_r[RS];
      dzero_r[0] <= szero_r[RS];
      dside_r[0] <= sside_r[RS];
    end
  end

  for (genvar k = 1; k <= FRAC; k++) begin : g_div
    logic [31:0] t_rem [3];
    logic        q_bit [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t_rem[i] = {dr_r[k-1][i], 1'b0};
        q_bit[i] = (t_rem[i] >= {1'b0, dlen_r[k-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvalid_r[k] <= 1'b0;
      end else if (en) begin
        dvalid_r[k] <= dvalid_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dr_r[k][i] <= q_bit[i] ? 31'(t_rem[i] - {1'b0, dlen_r[k-1]}) : 31'(t_rem[i]);
          dq_r[k][i] <= {dq_r[k-1][i][FRAC-1:0], q_bit[i]};
        end
        dlen_r[k] <= dlen_r[k-1];
        dneg_r[k] <= dneg_r[k-1];
        dzero_r[k] <= dzero_r[k-1];
        dside_r[k] <= dside_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (en) begin
      o_valid_r <= dvalid_r[FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dzero_r[FRAC]) begin
          o_n_r[i] <= '0;
        end else if (dneg_r[FRAC][i]) begin
          o_n_r[i] <= -$signed(32'(dq_r[FRAC][i]));
        end else begin
          o_n_r[i] <= $signed(32'(dq_r[FRAC][i]));
        end
      end
      o_zero_r <= dzero_r[FRAC];
      o_side_r <= dside_r[FRAC];
    end
  end

  assign out_valid = o_valid_r;
  assign out_n = o_n_r;
  assign out_zero = o_zero_r;
  assign out_side = o_side_r;

endmodule

[rtl/qsn_proj.sv]
`timescale 1ns / 1ps

module qsn_proj (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [31:0]   in_u [3],
  input  logic                 in_zero,
  input  qsn_pkg::side_t       in_side,
  output logic                 out_valid,
  output logic signed [qsn_pkg::RES_W-1:0] out_v [3]
);

  localparam int RW = qsn_pkg::RES_W;
  localparam int DW = qsn_pkg::DIFF_W;

  logic                 p1_valid_r, p2_valid_r, p3_valid_r, p4_valid_r, p5_valid_r;
  logic                 p6_valid_r;
  logic [63:0]          p1_prod_r [3];
  logic [2:0]           p1_neg_r;
  logic [30:0]          p1_umag_r [3], p2_umag_r [3], p3_umag_r [3], p4_umag_r [3];
  logic [2:0]           p1_uneg_r, p2_uneg_r, p3_uneg_r, p4_uneg_r;
  logic                 p1_zero_r, p2_zero_r, p3_zero_r, p4_zero_r, p5_zero_r;
  qsn_pkg::side_t       p1_side_r, p2_side_r, p3_side_r, p4_side_r, p5_side_r;
  logic signed [35:0]   p2_m_r;
  logic [49:0]          p3_plo_r;
  logic [48:0]          p3_phi_r;
  logic                 p3_mneg_r, p4_mneg_r;
  logic [42:0]          p4_ms_r;
  logic [52:0]          p5_qlo_r [3];
  logic [51:0]          p5_qhi_r [3];
  logic [2:0]           p5_neg_r;
  logic signed [RW-1:0] p6_v_r [3];

  logic signed [DW-1:0] d1 [3];
  logic [DW-1:0]        dmag1 [3];
  logic [30:0]          umag1 [3];
  logic signed [35:0]   m_nxt;
  logic [35:0]          mmag3;
  logic [66:0]          ms_prod;
  logic [73:0]          t_prod [3];
  logic [RW-1:0]        t_mag [3];
  logic signed [RW-1:0] t_signed [3];
  logic signed [RW-1:0] r_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1[i] = $signed(in_side.v[i]);
      dmag1[i] = d1[i][DW-1] ? DW'(-d1[i]) : DW'(d1[i]);
      umag1[i] = in_u[i][31] ? 31'(-in_u[i]) : 31'(in_u[i]);
    end
  end

  always_comb begin
    m_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (p1_neg_r[i]) begin
        m_nxt = m_nxt - $signed(36'(p1_prod_r[i][63:30]));
      end else begin
        m_nxt = m_nxt + $signed(36'(p1_prod_r[i][63:30]));
      end
    end
  end

  assign mmag3 = p2_m_r[35] ? 36'(-p2_m_r) : 36'(p2_m_r);
  assign ms_prod = (67'(p3_phi_r) << 18) + 67'(p3_plo_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_prod[i] = (74'(p5_qhi_r[i]) << 22) + 74'(p5_qlo_r[i]);
      t_mag[i] = t_prod[i][73:30];
      t_signed[i] = p5_neg_r[i] ? -$signed(t_mag[i]) : $signed(t_mag[i]);
      r_nxt[i] = RW'($signed(p5_side_r.v[i])) - t_signed[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
      p5_valid_r <= 1'b0;
      p6_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= in_valid;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      p4_valid_r <= p3_valid_r;
      p5_valid_r <= p4_valid_r;
      p6_valid_r <= p5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_prod_r[i] <= 64'(dmag1[i]) * 64'(umag1[i]);
        p1_neg_r[i] <= d1[i][DW-1] ^ in_u[i][31];
        p1_umag_r[i] <= umag1[i];
        p2_umag_r[i] <= p1_umag_r[i];
        p3_umag_r[i] <= p2_umag_r[i];
        p4_umag_r[i] <= p3_umag_r[i];
        p5_qlo_r[i] <= 53'(p4_ms_r[21:0]) * 53'(p4_umag_r[i]);
        p5_qhi_r[i] <= 52'(p4_ms_r[42:22]) * 52'(p4_umag_r[i]);
        p5_neg_r[i] <= p4_mneg_r ^ p4_uneg_r[i];
        if (p5_side_r.kind inside {qsn_pkg::KIND_CYL, qsn_pkg::KIND_CONE}) begin
          // A zero axis leaves a zero vector, which the next unit flags.
          p6_v_r[i] <= p5_zero_r ? '0 : r_nxt[i];
        end else begin
          p6_v_r[i] <= RW'($signed(p5_side_r.v[i]));
        end
      end
      p1_uneg_r <= {in_u[2][31], in_u[1][31], in_u[0][31]};
      p2_uneg_r <= p1_uneg_r;
      p3_uneg_r <= p2_uneg_r;
      p4_uneg_r <= p3_uneg_r;
      p1_zero_r <= in_zero;
      p2_zero_r <= p1_zero_r;
      p3_zero_r <= p2_zero_r;
      p4_zero_r <= p3_zero_r;
      p5_zero_r <= p4_zero_r;
      p1_side_r <= in_side;
      p2_side_r <= p1_side_r;
      p3_side_r <= p2_side_r;
      p4_side_r <= p3_side_r;
      p5_side_r <= p4_side_r;
      p2_m_r <= m_nxt;
      p3_plo_r <= 50'(mmag3[17:0]) * 50'(p2_side_r.scale);
      p3_phi_r <= 49'(mmag3[34:18]) * 49'(p2_side_r.scale);
      p3_mneg_r <= p2_m_r[35];
      p4_ms_r <= ms_prod[66:24];
      p4_mneg_r <= p3_mneg_r;
    end
  end

  assign out_valid = p6_valid_r;
  assign out_v = p6_v_r;

endmodule

[rtl/quadric_surface_normal.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    shape, hit, center, axis, cone scale
// out_     output     out_valid / out_ready  normal x, y, z and degenerate flag
//
// One request enters per cycle while the output is not stalled; a result passes
// the input register, the axis normalizer, the projection and the output normalizer,
// each normalizer a 31-stage square root and a bit-per-stage divider.
// Synchronous active-low reset clears every valid bit; payload is not reset.
// A stall at the output freezes the whole pipeline; the input register still
// takes one request while the result waits.

module quadric_surface_normal #(
  parameter int NORMAL_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_shape_kind,
  input  logic signed [31:0] in_hit_x,
  input  logic signed [31:0] in_hit_y,
  input  logic signed [31:0] in_hit_z,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_axis_x,
  input  logic signed [31:0] in_axis_y,
  input  logic signed [31:0] in_axis_z,
  input  logic [31:0]        in_cone_scale,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_normal_x,
  output logic signed [31:0] out_normal_y,
  output logic signed [31:0] out_normal_z,
  output logic               out_degenerate
);

  localparam int SIDE_W = $bits(qsn_pkg::side_t);
  localparam int DW = qsn_pkg::DIFF_W;
  localparam logic signed [31:0] ONE_N = 32'sd1 <<< NORMAL_FRAC_BITS;

  logic                 en;
  logic                 t0_valid_r;
  logic signed [31:0]   t0_axis_r [3];
  qsn_pkg::side_t       t0_side_r;
  qsn_pkg::side_t       side_nxt;
  logic signed [31:0]   hit_w [3];
  logic signed [31:0]   ctr_w [3];
  logic signed [31:0]   axis_w [3];
  logic signed [DW-1:0] d_w [3];

  logic                 a_valid;
  logic signed [31:0]   a_u [3];
  logic                 a_zero;
  logic [SIDE_W-1:0]    a_side_bits;
  qsn_pkg::side_t       a_side;
  logic                 p_valid;
  logic signed [qsn_pkg::RES_W-1:0] p_v [3];
  logic                 b_valid;
  logic signed [31:0]   b_n [3];
  logic                 b_zero;

  assign en = !b_valid || out_ready;
  assign in_ready = !t0_valid_r || en;

  assign hit_w = '{in_hit_x, in_hit_y, in_hit_z};
  assign ctr_w = '{in_center_x, in_center_y, in_center_z};
  assign axis_w = '{in_axis_x, in_axis_y, in_axis_z};

  // A plane's axis takes the place of the offset vector so that both
  // sphere and plane go straight to the final normalizer.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_w[i] = DW'(hit_w[i]) - DW'(ctr_w[i]);
      side_nxt.v[i] = (in_shape_kind == qsn_pkg::KIND_PLANE) ? DW'(axis_w[i]) : d_w[i];
    end
    side_nxt.kind = in_shape_kind;
    side_nxt.scale = (in_shape_kind == qsn_pkg::KIND_CONE) ? in_cone_scale
                                                          : qsn_pkg::ONE_SCALE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_valid_r <= 1'b0;
    end else if (in_ready) begin
      t0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      t0_axis_r <= axis_w;
      t0_side_r <= side_nxt;
    end
  end

  qsn_norm #(
    .IN_W   (32),
    .FRAC   (qsn_pkg::AXIS_FRAC),
    .SIDE_W (SIDE_W)
  ) u_axis_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t0_valid_r),
    .in_v      (t0_axis_r),
    .in_side   (t0_side_r),
    .out_valid (a_valid),
    .out_n     (a_u),
    .out_zero  (a_zero),
    .out_side  (a_side_bits)
  );

  assign a_side = qsn_pkg::side_t'(a_side_bits);

  qsn_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_valid),
    .in_u      (a_u),
    .in_zero   (a_zero),
    .in_side   (a_side),
    .out_valid (p_valid),
    .out_v     (p_v)
  );

  qsn_norm #(
    .IN_W   (qsn_pkg::RES_W),
    .FRAC   (NORMAL_FRAC_BITS),
    .SIDE_W (1)
  ) u_out_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_valid),
    .in_v      (p_v),
    .in_side   (1'b0),
    .out_valid (b_valid),
    .out_n     (b_n),
    .out_zero  (b_zero),
    .out_side  ()
  );

  assign out_valid = b_valid;
  assign out_normal_x = b_n[0];
  assign out_normal_y = b_n[1];
  assign out_normal_z = b_n[2];
  assign out_degenerate = b_zero;

`ifndef SYNTH
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == 0 && out_normal_y == 0 && out_normal_z == 0)
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_normal_x <= ONE_N && out_normal_x >= -ONE_N &&
      out_normal_y <= ONE_N && out_normal_y >= -ONE_N &&
      out_normal_z <= ONE_N && out_normal_z >= -ONE_N)
    else $error("normal component exceeds one");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    t0_valid_r && !en |=> t0_valid_r && $stable(t0_side_r))
    else $error("input register lost a request during a stall");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> t0_valid_r && out_valid && !out_ready)
    else $error("input blocked without a stall");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC = 30;
  localparam int LATENCY = 113 + FRAC;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_REQUESTS = 1500;

  typedef struct {
    logic signed [31:0] nx, ny, nz;
    logic degen;
  } normal_t;

  // Predictor for the normal unit. Products are sign-magnitude, truncated toward zero.
  class normal_scoreboard;
    normal_t pending[$];
    int errors;
    int checked;

    function automatic logic [63:0] mag(longint x);
      mag = (x < 0) ? -x : x;
    endfunction

    function automatic longint scaled_mul(longint a, longint b, int sh);
      logic [127:0] p;
      longint r;
      p = mag(a) * mag(b);
      r = longint'(p >> sh);
      scaled_mul = ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
        if (v >= r + bit_v) begin
          v -= r + bit_v;
          r = (r >> 1) + bit_v;
        end else begin
          r >>= 1;
        end
        bit_v >>= 2;
      end
      int_sqrt = r;
    endfunction

    function automatic bit unit_vector(input longint v[3], output longint n[3], input int f);
      logic [63:0] m[3];
      logic [63:0] mx, sum, len;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = mag(v[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        for (int i = 0; i < 3; i++) n[i] = 0;
        return 1;
      end
      while (mx >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) m[i] >>= 1;
        mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) m[i] <<= 1;
        mx <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        n[i] = longint'((m[i] << f) / len);
        if (v[i] < 0) n[i] = -n[i];
      end
      return 0;
    endfunction

    function void note_request(logic [1:0] kind, logic signed [31:0] hit[3],
                               logic signed [31:0] ctr[3], logic signed [31:0] ax[3],
                               logic [31:0] cone);
      longint d[3], a[3], u[3], r[3], n[3];
      longint m, ms, s;
      normal_t e;
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'(hit[i]) - longint'(ctr[i]);
        a[i] = longint'(ax[i]);
      end
      if (kind == qsn_pkg::KIND_SPHERE) begin
        e.degen = unit_vector(d, n, FRAC);
      end else if (kind == qsn_pkg::KIND_PLANE) begin
        e.degen = unit_vector(a, n, FRAC);
      end else if (unit_vector(a, u, qsn_pkg::AXIS_FRAC)) begin
        for (int i = 0; i < 3; i++) n[i] = 0;
        e.degen = 1;
      end else begin
        m = 0;
        for (int i = 0; i < 3; i++) m += scaled_mul(d[i], u[i], qsn_pkg::AXIS_FRAC);
        s = (kind == qsn_pkg::KIND_CONE) ? longint'({32'd0, cone})
                                         : longint'(qsn_pkg::ONE_SCALE);
        ms = scaled_mul(m, s, qsn_pkg::SCALE_FRAC);
        for (int i = 0; i < 3; i++)
          r[i] = d[i] - scaled_mul(ms, u[i], qsn_pkg::AXIS_FRAC);
        e.degen = unit_vector(r, n, FRAC);
      end
      e.nx = n[0][31:0];
      e.ny = n[1][31:0];
      e.nz = n[2][31:0];
      pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
      errors++;
    endtask

    task check_result(logic signed [31:0] nx, ny, nz, logic degen);
      normal_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (nx !== e.nx) report("normal_x", nx, e.nx);
      if (ny !== e.ny) report("normal_y", ny, e.ny);
      if (nz !== e.nz) report("normal_z", nz, e.nz);
      if (degen !== e.degen) report("degenerate", degen, e.degen);
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] in_shape_kind;
  logic signed [31:0] in_hit_x, in_hit_y, in_hit_z;
  logic signed [31:0] in_center_x, in_center_y, in_center_z;
  logic signed [31:0] in_axis_x, in_axis_y, in_axis_z;
  logic [31:0] in_cone_scale;
  logic signed [31:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  normal_scoreboard sb;
  bit idle_enable, backpressure_hold;
  int quiet_cycles;
  int kind_count[4];

  quadric_surface_normal #(.NORMAL_FRAC_BITS(FRAC)) DUT (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: rand_coord = $urandom;
      1: rand_coord = $signed($urandom_range(0, 16)) - 8;
      2: rand_coord = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: rand_coord = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // in_valid still high, so requests can follow back to back.
  task send_request(logic [1:0] kind, logic signed [31:0] hit[3], logic signed [31:0] ctr[3],
                    logic signed [31:0] ax[3], logic [31:0] cone);
    while (idle_enable && $urandom_range(0, 99) < 32) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_shape_kind <= kind;
    {in_hit_x, in_hit_y, in_hit_z} <= {hit[0], hit[1], hit[2]};
    {in_center_x, in_center_y, in_center_z} <= {ctr[0], ctr[1], ctr[2]};
    {in_axis_x, in_axis_y, in_axis_z} <= {ax[0], ax[1], ax[2]};
    in_cone_scale <= cone;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(kind, hit, ctr, ax, cone);
    kind_count[kind]++;
    @(negedge clk);
  endtask

  task send_random();
    logic signed [31:0] h[3], c[3], a[3];
    logic [1:0] k;
    logic [31:0] s;
    k = 2'($urandom_range(0, 3));
    for (int i = 0; i < 3; i++) begin
      h[i] = rand_coord();
      c[i] = ($urandom_range(0, 9) == 0) ? h[i] : rand_coord();
      a[i] = ($urandom_range(0, 19) == 0) ? 32'sd0 : rand_coord();
    end
    case ($urandom_range(0, 3))
      0: s = $urandom;
      1: s = $urandom_range(32'h01000000, 32'h04000000);
      2: s = $urandom_range(0, 32'h00ffffff);
      default: s = qsn_pkg::ONE_SCALE;
    endcase
    send_request(k, h, c, a, s);
  endtask

  task run_directed();
    logic signed [31:0] z[3], mx[3], mn[3], one[3], ax[3], h[3];
    z = '{0, 0, 0};
    mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    one = '{32'sh00010000, 0, 0};
    ax = '{0, 0, 32'sh00020000};
    h = '{32'sh00030000, -32'sh00010000, 32'sh00050000};
    // Zero vectors on every kind, then extreme points and axes.
    for (int k = 0; k < 4; k++) send_request(2'(k), z, z, z, qsn_pkg::ONE_SCALE);
    send_request(qsn_pkg::KIND_SPHERE, mx, mn, z, 32'hffffffff);
    send_request(qsn_pkg::KIND_SPHERE, mn, mx, mx, 0);
    send_request(qsn_pkg::KIND_SPHERE, one, z, z, 0);
    send_request(qsn_pkg::KIND_PLANE, h, mx, mn, 0);
    send_request(qsn_pkg::KIND_PLANE, h, z, mx, 32'hffffffff);
    send_request(qsn_pkg::KIND_CYL, h, z, ax, 0);
    send_request(qsn_pkg::KIND_CYL, mx, mn, mx, qsn_pkg::ONE_SCALE);
    // Hit on the axis collapses the cylinder normal to zero.
    send_request(qsn_pkg::KIND_CYL, ax, z, ax, qsn_pkg::ONE_SCALE);
    send_request(qsn_pkg::KIND_CONE, h, z, ax, qsn_pkg::ONE_SCALE);
    send_request(qsn_pkg::KIND_CONE, h, z, ax, 32'h02000000);
    send_request(qsn_pkg::KIND_CONE, h, z, ax, 0);
    send_request(qsn_pkg::KIND_CONE, mn, mx, mn, 32'hffffffff);
    send_request(qsn_pkg::KIND_CONE, h, one, z, 32'h03000000);
  endtask

  initial begin
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(negedge clk);
      if (backpressure_hold) out_ready <= 0;
      else out_ready <= !(idle_enable && $urandom_range(0, 99) < 32);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_normal_x, out_normal_y, out_normal_z, out_degenerate);
  end

  // Watchdog: counts cycles in which no request moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", sb.pending.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_shape_kind = 0;
    {in_hit_x, in_hit_y, in_hit_z} = '0;
    {in_center_x, in_center_y, in_center_z} = '0;
    {in_axis_x, in_axis_y, in_axis_z} = '0;
    in_cone_scale = 0;
    idle_enable = 1;
    backpressure_hold = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    run_directed();
    // Receiver holds off long enough for the pipeline to fill and block the input.
    fork
      begin
        backpressure_hold = 1;
        repeat (LATENCY * 3) @(posedge clk);
        backpressure_hold = 0;
      end
      begin
        repeat (LATENCY + 40) send_random();
        in_valid <= 0;
      end
    join
    @(negedge clk);
    idle_enable = 0;
    repeat (300) send_random();
    idle_enable = 1;
    repeat (RANDOM_REQUESTS - LATENCY - 340) send_random();
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d normals: plane %0d, sphere %0d, cylinder %0d, cone %0d",
             sb.checked, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("stall phases included a full-pipeline output hold of %0d cycles", LATENCY * 3);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
